// ===== hdl/q24_pkg.sv =====
`timescale 1ns / 1ps
package q24_pkg;

    localparam int FracBitsDefault = 8;
    localparam int DataW = 32;
    // The dividend grows by the fraction bits; the divider needs one quotient bit per dividend bit.
    localparam int DivW = DataW + 16;

    typedef enum logic [4:0] {
        CMD_ADD        = 5'd0,
        CMD_SUB        = 5'd1,
        CMD_MUL        = 5'd2,
        CMD_DIV        = 5'd3,
        CMD_LT         = 5'd4,
        CMD_GT         = 5'd5,
        CMD_LE         = 5'd6,
        CMD_GE         = 5'd7,
        CMD_EQ         = 5'd8,
        CMD_NE         = 5'd9,
        CMD_MIN        = 5'd10,
        CMD_MAX        = 5'd11,
        CMD_INC        = 5'd12,
        CMD_DEC        = 5'd13,
        CMD_FROM_INT   = 5'd14,
        CMD_TO_INT     = 5'd15,
        CMD_FROM_FLOAT = 5'd16,
        CMD_TO_FLOAT   = 5'd17
    } t_cmd;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DIV0  = 2'd1;
    localparam logic [1:0] STATUS_FLOAT = 2'd2;

    // Partial remainder and quotient handed from one divider cell to the next.
    typedef struct packed {
        logic [DivW-1:0] rem;
        logic [DivW-1:0] quo;
        logic [DataW-1:0] den;
        logic neg;
        logic div0;
    } t_div;

    typedef struct packed {
        logic valid;
        logic [DataW-1:0] result;
        logic cond;
        logic [1:0] status;
        logic is_div;
    } t_word;

endpackage

// ===== hdl/q24_div_cell.sv =====
`timescale 1ns / 1ps
module q24_div_cell
    import q24_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);

    logic [DataW:0] w_part;
    logic [DataW:0] w_diff;
    logic [DivW-1:0] w_rem;
    logic [DivW-1:0] w_quo;

    // One restoring-division step: try the divisor against the remainder bits at this position.
    always_comb begin
        w_part = (DataW+1)'(i_d.rem >> BIT);
        w_diff = w_part - {1'b0, i_d.den};
        w_rem = i_d.rem;
        w_quo = i_d.quo;
        if (!w_diff[DataW]) begin
            w_rem = i_d.rem - (DivW'({1'b0, i_d.den}) << BIT);
            w_quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d.rem <= w_rem;
            o_d.quo <= w_quo;
            o_d.den <= i_d.den;
            o_d.neg <= i_d.neg;
            o_d.div0 <= i_d.div0;
        end
    end

endmodule

// ===== hdl/q24_alu_stage.sv =====
`timescale 1ns / 1ps
module q24_alu_stage
    import q24_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [4:0]        i_cmd,
    input  logic [DataW-1:0]  i_a,
    input  logic [DataW-1:0]  i_b,
    output logic [DataW-1:0]  o_result,
    output logic              o_cond,
    output logic [1:0]        o_status
);

    localparam int Bias = 150 - FRAC_BITS;

    logic signed [DataW-1:0] w_sa, w_sb;
    logic signed [2*DataW-1:0] r_prod;
    logic [4:0] r_cmd;
    logic [DataW-1:0] r_a, r_b;
    logic [DataW-1:0] n_res, w_fres, w_tres, w_res1;
    logic n_cond;
    logic [1:0] n_status, w_fstat;
    logic [DataW-1:0] w_diffmul;

    assign w_sa = i_a;
    assign w_sb = i_b;

    // Stage one: multiply and latch the operands. Stage two: everything else.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_sa * w_sb;
            r_cmd <= i_cmd;
            r_a <= i_a;
            r_b <= i_b;
        end
    end

    assign w_diffmul = r_prod[FRAC_BITS +: DataW];

    // Float to fixed.
    always_comb begin
        logic [7:0] ex;
        logic [23:0] mant;
        logic [40:0] mag;
        int sh;
        ex = r_a[30:23];
        mant = {1'b1, r_a[22:0]};
        mag = '0;
        sh = int'(ex) - Bias;
        w_fstat = STATUS_OK;
        w_fres = '0;
        if (ex == 8'hFF) begin
            w_fstat = STATUS_FLOAT;
            if (r_a[22:0] != 0) w_fres = '0;
            else w_fres = r_a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (ex != 0) begin
            // Any left shift past 16 already lies beyond both bounds.
            if (sh >= 0) begin
                if (sh > 16) mag = 41'(1) << 40;
                else mag = 41'(mant) << sh;
            end else if (-sh <= 25) begin
                mag = (41'(mant) + (41'(1) << (-sh - 1))) >> (-sh);
            end
            if (r_a[31]) begin
                if (mag > 41'h0_8000_0000) begin
                    w_fstat = STATUS_FLOAT;
                    w_fres = 32'h8000_0000;
                end else begin
                    w_fres = 32'(0) - mag[31:0];
                end
            end else if (mag > 41'h0_7FFF_FFFF) begin
                w_fstat = STATUS_FLOAT;
                w_fres = 32'h7FFF_FFFF;
            end else begin
                w_fres = mag[31:0];
            end
        end
    end

    // Fixed to float, round to nearest even.
    always_comb begin
        logic [DataW-1:0] mag;
        logic [DataW-1:0] norm;
        logic [5:0] p;
        logic [24:0] keep;
        logic grd, stk;
        mag = r_a[31] ? (32'(0) - r_a) : r_a;
        p = '0;
        for (int i = 0; i < DataW; i++) begin
            if (mag[i]) p = 6'(i);
        end
        norm = mag << (6'd31 - p);
        keep = {1'b0, norm[31:8]};
        grd = norm[7];
        stk = |norm[6:0];
        if (grd && (stk || keep[0])) keep = keep + 25'd1;
        if (keep[24]) begin
            keep = keep >> 1;
            p = p + 6'd1;
        end
        w_tres = (mag == 0) ? '0 :
            {r_a[31], 8'(10'(p) + 10'd127 - 10'(FRAC_BITS)), keep[22:0]};
    end

    always_comb begin
        logic signed [DataW-1:0] sa, sb;
        sa = r_a;
        sb = r_b;
        n_res = '0;
        n_cond = 1'b0;
        n_status = STATUS_OK;
        case (r_cmd)
            CMD_ADD:        n_res = r_a + r_b;
            CMD_SUB:        n_res = r_a - r_b;
            CMD_MUL:        n_res = w_diffmul;
            CMD_LT:         n_cond = sa < sb;
            CMD_GT:         n_cond = sa > sb;
            CMD_LE:         n_cond = sa <= sb;
            CMD_GE:         n_cond = sa >= sb;
            CMD_EQ:         n_cond = sa == sb;
            CMD_NE:         n_cond = sa != sb;
            CMD_MIN:        n_res = (sa <= sb) ? r_a : r_b;
            CMD_MAX:        n_res = (sa >= sb) ? r_a : r_b;
            CMD_INC:        n_res = r_a + 32'd1;
            CMD_DEC:        n_res = r_a - 32'd1;
            CMD_FROM_INT:   n_res = r_a << FRAC_BITS;
            CMD_TO_INT:     n_res = 32'(sa >>> FRAC_BITS);
            CMD_FROM_FLOAT: begin
                n_res = w_fres;
                n_status = w_fstat;
            end
            CMD_TO_FLOAT:   n_res = w_tres;
            default:        n_res = '0;
        endcase
    end

    assign w_res1 = n_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_result <= w_res1;
            o_cond <= n_cond;
            o_status <= n_status;
        end
    end

endmodule

// ===== hdl/q24_8_fixed_point_alu.sv =====
`timescale 1ns / 1ps
// Signed Q24.8 arithmetic unit. It takes one word per clock while not stalled and returns
// one result word per input word, in order. A divide passes through the input register,
// a chain of 40 restoring-division cells (one quotient bit per cell for the 40-bit
// dividend), a sign-correction stage and the output register. All other commands go
// through a short two-stage path and a delay line that lines them up with the divider.
// The whole pipeline advances whenever the output register is empty or being read, so
// throughput is one word per cycle.
module q24_8_fixed_point_alu
    import q24_pkg::*;
#(
    parameter int FRAC_BITS = FracBitsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [4:0]         i_cmd,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_result,
    output logic               o_cond,
    output logic [1:0]         o_status
);

    localparam int Cells = DataW + FRAC_BITS;
    localparam int Lat = Cells + 2;

    logic w_en;
    logic [Lat-1:0] r_vld;
    logic [Lat-1:0] r_isdiv;
    t_div w_chain [0:Cells];
    logic [DataW-1:0] w_mag_a, w_mag_b;
    logic [DataW-1:0] w_alu_res;
    logic w_alu_cond;
    logic [1:0] w_alu_stat;
    logic [DataW-1:0] r_dres [0:Lat-3];
    logic r_dcond [0:Lat-3];
    logic [1:0] r_dstat [0:Lat-3];
    logic [DataW-1:0] r_q;
    logic r_qdiv0;

    // The pipeline stalls only when the output word is held.
    assign w_en = !o_valid || i_ready;
    assign o_ready = w_en;

    assign w_mag_a = i_operand_a[31] ? (32'(0) - i_operand_a) : i_operand_a;
    assign w_mag_b = i_operand_b[31] ? (32'(0) - i_operand_b) : i_operand_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            w_chain[0].rem <= DivW'(w_mag_a) << FRAC_BITS;
            w_chain[0].quo <= '0;
            w_chain[0].den <= w_mag_b;
            w_chain[0].neg <= i_operand_a[31] ^ i_operand_b[31];
            w_chain[0].div0 <= (i_operand_b == 0);
        end
    end

    for (genvar g = 0; g < Cells; g++) begin : g_cell
        q24_div_cell #(.BIT(Cells - 1 - g)) u_cell (
            .i_clk(i_clk),
            .i_en (w_en),
            .i_d  (w_chain[g]),
            .o_d  (w_chain[g+1])
        );
    end

    q24_alu_stage #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cmd   (i_cmd),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .o_result(w_alu_res),
        .o_cond  (w_alu_cond),
        .o_status(w_alu_stat)
    );

    // Delay line for the non-divide results so both paths line up.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dres[0] <= w_alu_res;
            r_dcond[0] <= w_alu_cond;
            r_dstat[0] <= w_alu_stat;
            for (int i = 1; i < Lat - 2; i++) begin
                r_dres[i] <= r_dres[i-1];
                r_dcond[i] <= r_dcond[i-1];
                r_dstat[i] <= r_dstat[i-1];
            end
            r_q <= w_chain[Cells].neg ? (32'(0) - w_chain[Cells].quo[DataW-1:0])
                                      : w_chain[Cells].quo[DataW-1:0];
            r_qdiv0 <= w_chain[Cells].div0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_isdiv <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
            r_isdiv <= {r_isdiv[Lat-2:0], i_cmd == CMD_DIV};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_vld[Lat-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_isdiv[Lat-1]) begin
                o_result <= r_qdiv0 ? '0 : r_q;
                o_cond <= 1'b0;
                o_status <= r_qdiv0 ? STATUS_DIV0 : STATUS_OK;
            end else begin
                o_result <= r_dres[Lat-3];
                o_cond <= r_dcond[Lat-3];
                o_status <= r_dstat[Lat-3];
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("output word changed while stalled");
    a_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cond |-> o_status == STATUS_OK)
        else $error("comparison flagged a status");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("stalled with empty output");

endmodule
